@@ hdl/fcca_pkg.sv @@
// ============================================================================
// fcca_pkg
// Shared types and constants for the cluster chain allocator.
// ============================================================================
package fcca_pkg;

    // Default sizes, handed down from the top level parameters.
    localparam int DEF_CLUSTERS      = 256;
    localparam int DEF_DIR_ENTRIES   = 4;
    localparam int DEF_CLUSTER_BYTES = 4;

    // Field widths of the stream beats.
    localparam int KIND_W   = 2;
    localparam int NAME_W   = 64;
    localparam int BYTES_W  = 10;
    localparam int IDX_W    = 8;
    localparam int STATUS_W = 3;
    localparam int FIRST_W  = 8;
    localparam int ENTRY_W  = 16;

    // Table entry markers.
    localparam logic [ENTRY_W-1:0] END_MARK   = 16'hFFFF;
    localparam logic [ENTRY_W-1:0] LAST_LIMIT = 16'hFFF8;
    localparam logic [ENTRY_W-1:0] FREE_MARK  = 16'h0000;

    // Byte accumulators: large enough for a size plus two cluster sizes.
    localparam int ACC_W = 15;
    // Once the free byte count reaches this value any size fits.
    localparam logic [ACC_W-1:0] ACC_SAT = ACC_W'(1 << BYTES_W);

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATE = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_FIND   = 2'd2,
        KIND_FOLLOW = 2'd3
    } fcca_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_EXISTS   = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_NOSPACE  = 3'd3,
        STAT_NOTFOUND = 3'd4,
        STAT_ZERO     = 3'd5
    } fcca_status_t;

    typedef enum logic [3:0] {
        CLEARING,
        IDLE,
        LOOKUP,
        COUNT,
        LINK,
        LINK_END,
        WALK_RD,
        WALK_WR,
        FOLLOW,
        FOLLOW_DATA,
        RESPOND
    } fcca_state_t;

    // Commands from the engine to the directory.
    typedef struct packed {
        logic scan;   // start a name lookup over all slots
        logic write;  // store name and start in the free slot found by the scan
        logic clear;  // drop the slot matched by the scan
    } dir_cmd_t;

    // Directory lookup outcome, valid while done is high and held afterwards.
    typedef struct packed {
        logic done;
        logic hit;
        logic free_ok;
    } dir_stat_t;

endpackage

@@ hdl/fat_cluster_chain_allocator.sv @@
// ============================================================================
// fat_cluster_chain_allocator
// FAT-style cluster table and small file directory behind stream ports.
// ============================================================================
// The block takes one command beat at a time and returns exactly one result
// beat for it. Create checks the name and a free directory slot, counts the
// free table entries, then links the needed clusters in ascending order and
// closes the chain with 0xFFFF. Delete looks up the name, drops the slot and
// walks the chain, zeroing each entry. Find returns a file's first cluster and
// follow returns one raw table entry. The cluster table lives in one RAM with
// a single read and a single write port, and every table command is paced by
// that read port: one table entry per cycle while counting and linking, and
// while walking a chain each entry is read in WALK_RD and zeroed in WALK_WR.
// A name lookup reads one directory slot per cycle. After reset a clearing
// pass initializes the table; no beat is accepted until it ends. A finished
// result sits in the output register while the next beat can already be
// accepted.
// ============================================================================
module fat_cluster_chain_allocator #(
    parameter int CLUSTERS      = fcca_pkg::DEF_CLUSTERS,
    parameter int DIR_ENTRIES   = fcca_pkg::DEF_DIR_ENTRIES,
    parameter int CLUSTER_BYTES = fcca_pkg::DEF_CLUSTER_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // file_name [63:0], byte_count [73:64], cluster_index [81:74], zero fill
    input  logic [87:0] s_axis_tdata,
    // kind [1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status [2:0], first_cluster [10:3], table_entry [26:11], zero fill
    output logic [31:0] m_axis_tdata
);

    import fcca_pkg::*;

    logic                out_valid_reg, out_valid_next;
    logic [31:0]         out_data_reg, out_data_next;
    logic                out_free;
    logic                resp_valid;
    fcca_status_t        resp_status;
    logic [FIRST_W-1:0]  resp_first;
    logic [ENTRY_W-1:0]  resp_entry;
    fcca_kind_t          req_kind;

    assign req_kind = fcca_kind_t'(s_axis_tuser);

    fcca_engine #(
        .CLUSTERS      (CLUSTERS),
        .DIR_ENTRIES   (DIR_ENTRIES),
        .CLUSTER_BYTES (CLUSTER_BYTES)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_axis_tvalid),
        .req_ready   (s_axis_tready),
        .req_kind    (req_kind),
        .req_name    (s_axis_tdata[63:0]),
        .req_bytes   (s_axis_tdata[73:64]),
        .req_idx     (s_axis_tdata[81:74]),
        .resp_valid  (resp_valid),
        .out_free    (out_free),
        .resp_status (resp_status),
        .resp_first  (resp_first),
        .resp_entry  (resp_entry)
    );

    // The output register can take a new result when it is empty or its
    // current beat is being taken in this cycle.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_free)
        begin
            out_valid_next = resp_valid;
            if (resp_valid)
            begin
                out_data_next = {5'b0, resp_entry, resp_first, resp_status};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ hdl/fcca_ram.sv @@
// ============================================================================
// fcca_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module fcca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/fcca_dir.sv @@
// ============================================================================
// fcca_dir
// File directory: name and start cluster in RAM, valid bits in flops, and a
// slot-by-slot lookup that finds the matching slot and the lowest free slot.
// ============================================================================
module fcca_dir #(
    parameter int DIR_ENTRIES = fcca_pkg::DEF_DIR_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fcca_pkg::dir_cmd_t           cmd,
    input  logic [fcca_pkg::NAME_W-1:0]  name,
    input  logic [fcca_pkg::FIRST_W-1:0] wr_start,
    output fcca_pkg::dir_stat_t          stat,
    output logic [fcca_pkg::FIRST_W-1:0] hit_start
);

    import fcca_pkg::*;

    localparam int SW = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int DW = FIRST_W + NAME_W;
    localparam logic [SW-1:0] LAST_SLOT = SW'(DIR_ENTRIES - 1);

    logic [DIR_ENTRIES-1:0] valid_reg, valid_next;
    logic [SW-1:0]          scan_idx_reg, scan_idx_next;
    logic                   scan_on_reg, scan_on_next;
    logic                   ph_valid_reg, ph_valid_next;
    logic [SW-1:0]          ph_slot_reg, ph_slot_next;
    logic                   hit_reg, hit_next;
    logic                   free_ok_reg, free_ok_next;
    logic                   done_reg, done_next;
    logic [SW-1:0]          hit_slot_reg, hit_slot_next;
    logic [SW-1:0]          free_slot_reg, free_slot_next;
    logic [FIRST_W-1:0]     hit_start_reg, hit_start_next;
    logic [DW-1:0]          rd_data;
    logic                   slot_match;

    fcca_ram #(
        .WIDTH (DW),
        .DEPTH (DIR_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.write),
        .wr_addr (free_slot_reg),
        .wr_data ({wr_start, name}),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    // Empty slots never match, whatever their RAM contents.
    assign slot_match = valid_reg[ph_slot_reg] && (rd_data[NAME_W-1:0] == name);

    always_comb
    begin
        valid_next     = valid_reg;
        scan_idx_next  = scan_idx_reg;
        scan_on_next   = scan_on_reg;
        ph_valid_next  = 1'b0;
        ph_slot_next   = scan_idx_reg;
        hit_next       = hit_reg;
        free_ok_next   = free_ok_reg;
        hit_slot_next  = hit_slot_reg;
        free_slot_next = free_slot_reg;
        hit_start_next = hit_start_reg;
        done_next      = ph_valid_reg && (ph_slot_reg == LAST_SLOT);

        if (cmd.scan)
        begin
            scan_idx_next = '0;
            scan_on_next  = 1'b1;
            hit_next      = 1'b0;
            free_ok_next  = 1'b0;
        end
        else if (scan_on_reg)
        begin
            ph_valid_next = 1'b1;
            if (scan_idx_reg == LAST_SLOT)
            begin
                scan_on_next = 1'b0;
            end
            else
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
        end

        if (ph_valid_reg)
        begin
            if (slot_match && !hit_reg)
            begin
                hit_next       = 1'b1;
                hit_slot_next  = ph_slot_reg;
                hit_start_next = rd_data[DW-1:NAME_W];
            end
            if (!valid_reg[ph_slot_reg] && !free_ok_reg)
            begin
                free_ok_next   = 1'b1;
                free_slot_next = ph_slot_reg;
            end
        end

        if (cmd.write)
        begin
            valid_next[free_slot_reg] = 1'b1;
        end
        if (cmd.clear)
        begin
            valid_next[hit_slot_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            scan_on_reg  <= 1'b0;
            ph_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            free_ok_reg  <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            scan_on_reg  <= scan_on_next;
            ph_valid_reg <= ph_valid_next;
            done_reg     <= done_next;
            hit_reg      <= hit_next;
            free_ok_reg  <= free_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg  <= scan_idx_next;
        ph_slot_reg   <= ph_slot_next;
        hit_slot_reg  <= hit_slot_next;
        free_slot_reg <= free_slot_next;
        hit_start_reg <= hit_start_next;
    end

    assign stat.done    = done_reg;
    assign stat.hit     = hit_reg;
    assign stat.free_ok = free_ok_reg;
    assign hit_start    = hit_start_reg;

    // A slot is only written when the lookup found it free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> free_ok_reg && !valid_reg[free_slot_reg])
        else $error("directory write to a slot that is not free");

    // A slot is only dropped when the lookup matched it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> hit_reg && valid_reg[hit_slot_reg])
        else $error("directory clear without a matched slot");

    // The done pulse lasts one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("directory done held for more than one cycle");

endmodule

@@ hdl/fcca_engine.sv @@
// ============================================================================
// fcca_engine
// Command sequencer around the cluster table RAM: clearing pass, free count,
// first-fit linking, chain walk on delete and single entry reads.
// ============================================================================
module fcca_engine #(
    parameter int CLUSTERS      = fcca_pkg::DEF_CLUSTERS,
    parameter int DIR_ENTRIES   = fcca_pkg::DEF_DIR_ENTRIES,
    parameter int CLUSTER_BYTES = fcca_pkg::DEF_CLUSTER_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  fcca_pkg::fcca_kind_t          req_kind,
    input  logic [fcca_pkg::NAME_W-1:0]   req_name,
    input  logic [fcca_pkg::BYTES_W-1:0]  req_bytes,
    input  logic [fcca_pkg::IDX_W-1:0]    req_idx,
    output logic                          resp_valid,
    input  logic                          out_free,
    output fcca_pkg::fcca_status_t        resp_status,
    output logic [fcca_pkg::FIRST_W-1:0]  resp_first,
    output logic [fcca_pkg::ENTRY_W-1:0]  resp_entry
);

    import fcca_pkg::*;

    localparam int CW     = $clog2(CLUSTERS);
    localparam int STEP_W = $clog2(CLUSTERS + 1);
    localparam logic [CW-1:0]      LAST_IDX  = CW'(CLUSTERS - 1);
    localparam logic [ENTRY_W-1:0] CL_LIMIT  = ENTRY_W'(CLUSTERS);
    localparam logic [STEP_W-1:0]  STEP_MAX  = STEP_W'(CLUSTERS);
    localparam logic [ACC_W-1:0]   CB_ACC    = ACC_W'(CLUSTER_BYTES);

    fcca_state_t        state_reg, state_next;
    fcca_kind_t         kind_reg, kind_next;
    logic [NAME_W-1:0]  name_reg, name_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    fcca_status_t       status_reg, status_next;
    logic [FIRST_W-1:0] first_reg, first_next;
    logic [ENTRY_W-1:0] entry_reg, entry_next;
    logic [CW-1:0]      clr_idx_reg, clr_idx_next;
    logic [CW-1:0]      scan_idx_reg, scan_idx_next;
    logic               iss_reg, iss_next;
    logic               ph_valid_reg, ph_valid_next;
    logic [CW-1:0]      ph_idx_reg, ph_idx_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [CW-1:0]      prev_reg, prev_next;
    logic [ENTRY_W-1:0] cur_reg, cur_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;

    logic               tbl_wr_en;
    logic [CW-1:0]      tbl_wr_addr;
    logic [ENTRY_W-1:0] tbl_wr_data;
    logic [CW-1:0]      tbl_rd_addr;
    logic [ENTRY_W-1:0] tbl_rd_data;
    dir_cmd_t           dir_cmd;
    dir_stat_t          dir_stat;
    logic [FIRST_W-1:0] dir_hit_start;

    logic               ph_free;
    logic [ACC_W-1:0]   free_sum;
    logic [ACC_W-1:0]   taken_sum;
    logic [ACC_W-1:0]   bytes_acc;

    fcca_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CLUSTERS)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    fcca_dir #(
        .DIR_ENTRIES (DIR_ENTRIES)
    ) u_dir (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dir_cmd),
        .name      (name_reg),
        .wr_start  (first_reg),
        .stat      (dir_stat),
        .hit_start (dir_hit_start)
    );

    assign ph_free   = ph_valid_reg && (tbl_rd_data == FREE_MARK);
    assign bytes_acc = ACC_W'(bytes_reg);
    // Free bytes seen so far, saturating once any size would fit.
    assign free_sum  = (ph_free && (acc_reg < ACC_SAT)) ? (acc_reg + CB_ACC) : acc_reg;
    // Bytes covered once the cluster in the compare stage is taken.
    assign taken_sum = acc_reg + CB_ACC;

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        name_next     = name_reg;
        bytes_next    = bytes_reg;
        idx_next      = idx_reg;
        status_next   = status_reg;
        first_next    = first_reg;
        entry_next    = entry_reg;
        clr_idx_next  = clr_idx_reg;
        scan_idx_next = scan_idx_reg;
        iss_next      = iss_reg;
        ph_valid_next = 1'b0;
        ph_idx_next   = scan_idx_reg;
        acc_next      = acc_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        steps_next    = steps_reg;

        tbl_wr_en     = 1'b0;
        tbl_wr_addr   = prev_reg;
        tbl_wr_data   = FREE_MARK;
        tbl_rd_addr   = scan_idx_reg;
        dir_cmd       = '0;
        req_ready     = 1'b0;
        resp_valid    = 1'b0;

        unique case (state_reg)
            CLEARING:
            begin
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = clr_idx_reg;
                if (clr_idx_reg == LAST_IDX)
                begin
                    tbl_wr_data = END_MARK;
                    state_next  = IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end

            IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    kind_next   = req_kind;
                    name_next   = req_name;
                    bytes_next  = req_bytes;
                    idx_next    = req_idx;
                    status_next = STAT_OK;
                    first_next  = '0;
                    entry_next  = '0;
                    if (req_kind == KIND_FOLLOW)
                    begin
                        state_next = FOLLOW;
                    end
                    else
                    begin
                        dir_cmd.scan = 1'b1;
                        state_next   = LOOKUP;
                    end
                end
            end

            LOOKUP:
            begin
                if (dir_stat.done)
                begin
                    state_next = RESPOND;
                    case (kind_reg)
                        KIND_CREATE:
                        begin
                            if (dir_stat.hit)
                            begin
                                status_next = STAT_EXISTS;
                            end
                            else if (!dir_stat.free_ok)
                            begin
                                status_next = STAT_FULL;
                            end
                            else if (bytes_acc < CB_ACC)
                            begin
                                status_next = STAT_ZERO;
                            end
                            else
                            begin
                                scan_idx_next = '0;
                                iss_next      = 1'b1;
                                acc_next      = '0;
                                state_next    = COUNT;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (!dir_stat.hit)
                            begin
                                status_next = STAT_NOTFOUND;
                            end
                            else
                            begin
                                dir_cmd.clear = 1'b1;
                                cur_next      = ENTRY_W'(dir_hit_start);
                                steps_next    = '0;
                                state_next    = WALK_RD;
                            end
                        end
                        default:
                        begin
                            if (dir_stat.hit)
                            begin
                                first_next = dir_hit_start;
                            end
                            else
                            begin
                                status_next = STAT_NOTFOUND;
                            end
                        end
                    endcase
                end
            end

            COUNT:
            begin
                ph_valid_next = iss_reg;
                if (iss_reg)
                begin
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                acc_next = free_sum;
                if (ph_valid_reg && (ph_idx_reg == LAST_IDX))
                begin
                    ph_valid_next = 1'b0;
                    if ((free_sum + CB_ACC) <= bytes_acc)
                    begin
                        status_next = STAT_NOSPACE;
                        state_next  = RESPOND;
                    end
                    else
                    begin
                        scan_idx_next = '0;
                        iss_next      = 1'b1;
                        acc_next      = '0;
                        state_next    = LINK;
                    end
                end
            end

            LINK:
            begin
                ph_valid_next = iss_reg;
                if (iss_reg)
                begin
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                if (ph_free)
                begin
                    if (acc_reg == '0)
                    begin
                        first_next = FIRST_W'(ph_idx_reg);
                    end
                    else
                    begin
                        tbl_wr_en   = 1'b1;
                        tbl_wr_data = ENTRY_W'(ph_idx_reg);
                    end
                    prev_next = ph_idx_reg;
                    acc_next  = taken_sum;
                    if ((taken_sum + CB_ACC) > bytes_acc)
                    begin
                        iss_next   = 1'b0;
                        state_next = LINK_END;
                    end
                end
            end

            LINK_END:
            begin
                tbl_wr_en     = 1'b1;
                tbl_wr_data   = END_MARK;
                dir_cmd.write = 1'b1;
                status_next   = STAT_OK;
                state_next    = RESPOND;
            end

            WALK_RD:
            begin
                tbl_rd_addr = CW'(cur_reg);
                if ((cur_reg >= LAST_LIMIT) || (cur_reg >= CL_LIMIT) || (steps_reg == STEP_MAX))
                begin
                    state_next = RESPOND;
                end
                else
                begin
                    state_next = WALK_WR;
                end
            end

            WALK_WR:
            begin
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = CW'(cur_reg);
                tbl_wr_data = FREE_MARK;
                cur_next    = tbl_rd_data;
                steps_next  = steps_reg + 1'b1;
                state_next  = WALK_RD;
            end

            FOLLOW:
            begin
                tbl_rd_addr = CW'(idx_reg);
                if (ENTRY_W'(idx_reg) >= CL_LIMIT)
                begin
                    status_next = STAT_NOTFOUND;
                    state_next  = RESPOND;
                end
                else
                begin
                    state_next = FOLLOW_DATA;
                end
            end

            FOLLOW_DATA:
            begin
                entry_next = tbl_rd_data;
                state_next = RESPOND;
            end

            RESPOND:
            begin
                resp_valid = 1'b1;
                if (out_free)
                begin
                    state_next = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= CLEARING;
            clr_idx_reg  <= '0;
            iss_reg      <= 1'b0;
            ph_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            iss_reg      <= iss_next;
            ph_valid_reg <= ph_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        name_reg     <= name_next;
        bytes_reg    <= bytes_next;
        idx_reg      <= idx_next;
        status_reg   <= status_next;
        first_reg    <= first_next;
        entry_reg    <= entry_next;
        scan_idx_reg <= scan_idx_next;
        ph_idx_reg   <= ph_idx_next;
        acc_reg      <= acc_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        steps_reg    <= steps_next;
    end

    assign resp_status = status_reg;
    assign resp_first  = first_reg;
    assign resp_entry  = entry_reg;

    // Every accepted beat leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg != IDLE))
        else $error("accepted beat did not start a command");

    // Closing a chain always ends in a successful create.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == LINK_END) |=> (state_reg == RESPOND) && (status_reg == STAT_OK))
        else $error("chain end without a successful create");

    // A space refusal only follows a non-zero cluster count.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == RESPOND) && (status_reg == STAT_NOSPACE)) |-> (bytes_acc >= CB_ACC))
        else $error("space refusal for a zero cluster count");

    // The delete walk is bounded by the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == WALK_WR) |-> (steps_reg < STEP_MAX))
        else $error("chain walk ran past the table size");

endmodule
